@@ rtl/tcp_option_parser_defines.svh @@
// Assertion helpers for the option parser checker.
`ifndef TCP_OPTION_PARSER_DEFINES_SVH
`define TCP_OPTION_PARSER_DEFINES_SVH

// Clocked property, masked while reset is held.
`define TCPOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Output value must hold while a beat is stalled.
`define TCPOP_ASSERT_HOLD(lbl, sig, msg) \
  `TCPOP_ASSERT(lbl, out_tvalid && !out_tready |=> $stable(sig), msg)

`endif

@@ rtl/tcpop_pkg.sv @@
`default_nettype none

package tcpop_pkg;

  typedef enum logic [3:0] {
    RK_EOL     = 4'd0,
    RK_NOP     = 4'd1,
    RK_MSS     = 4'd2,
    RK_WSCALE  = 4'd3,
    RK_SACKOK  = 4'd4,
    RK_SACKBLK = 4'd5,
    RK_MALSACK = 4'd6,
    RK_TS      = 4'd7,
    RK_UNKNOWN = 4'd8,
    RK_TRUNC   = 4'd9,
    RK_BADSACK = 4'd10
  } rk_t;

  typedef enum logic [2:0] {
    PH_KIND = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // option kind bytes on the wire
  localparam logic [7:0] OPT_EOL    = 8'd0;
  localparam logic [7:0] OPT_NOP    = 8'd1;
  localparam logic [7:0] OPT_MSS    = 8'd2;
  localparam logic [7:0] OPT_WSCALE = 8'd3;
  localparam logic [7:0] OPT_SACKOK = 8'd4;
  localparam logic [7:0] OPT_SACK   = 8'd5;
  localparam logic [7:0] OPT_TS     = 8'd8;

  // payload bytes of the fixed-length options
  localparam logic [7:0] LEN_MSS    = 8'd2;
  localparam logic [7:0] LEN_WSCALE = 8'd1;
  localparam logic [7:0] LEN_TS     = 8'd8;
  localparam logic [7:0] SACK_HDR   = 8'd2;

  localparam int OUT_TDATA_W = 80;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    rk_t        kind;       // option kind if this byte were a kind byte
    logic       len_short;  // as a sack length: below header size
    logic       len_mal;    // as a sack length: payload zero or not 8-aligned
    logic [7:0] len_left;   // as a sack length: payload bytes
  } tok_t;

  typedef struct packed {
    rk_t         kind;
    logic [31:0] first;
    logic [31:0] second;
    logic [4:0]  idx;
    logic [4:0]  cnt;
    logic        done;
  } rec_t;

endpackage

`default_nettype wire

@@ rtl/tcpop_front.sv @@
`default_nettype none

module tcpop_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       in_data,
  input  wire              in_last,
  output logic             tok_valid,
  input  wire              tok_ready,
  output tcpop_pkg::tok_t  tok
);

  logic            tok_valid_r;
  tcpop_pkg::tok_t tok_r;
  tcpop_pkg::tok_t tok_nxt;

  always_comb begin
    tok_nxt.data = in_data;
    tok_nxt.last = in_last;
    case (in_data)
      tcpop_pkg::OPT_EOL:    tok_nxt.kind = tcpop_pkg::RK_EOL;
      tcpop_pkg::OPT_NOP:    tok_nxt.kind = tcpop_pkg::RK_NOP;
      tcpop_pkg::OPT_MSS:    tok_nxt.kind = tcpop_pkg::RK_MSS;
      tcpop_pkg::OPT_WSCALE: tok_nxt.kind = tcpop_pkg::RK_WSCALE;
      tcpop_pkg::OPT_SACKOK: tok_nxt.kind = tcpop_pkg::RK_SACKOK;
      tcpop_pkg::OPT_SACK:   tok_nxt.kind = tcpop_pkg::RK_SACKBLK;
      tcpop_pkg::OPT_TS:     tok_nxt.kind = tcpop_pkg::RK_TS;
      default:               tok_nxt.kind = tcpop_pkg::RK_UNKNOWN;
    endcase
    tok_nxt.len_short = (in_data < tcpop_pkg::SACK_HDR);
    tok_nxt.len_left  = in_data - tcpop_pkg::SACK_HDR;
    tok_nxt.len_mal   = (tok_nxt.len_left == 8'd0) || (tok_nxt.len_left[2:0] != 3'd0);
  end

  assign in_ready  = !tok_valid_r || tok_ready;
  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      tok_valid_r <= 1'b1;
    end else if (tok_ready) begin
      tok_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcpop_fifo.sv @@
`default_nettype none

module tcpop_fifo #(
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  tcpop_pkg::tok_t  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output tcpop_pkg::tok_t  pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcpop_pkg::tok_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcpop_back.sv @@
`default_nettype none

module tcpop_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              tok_valid,
  output logic             tok_ready,
  input  tcpop_pkg::tok_t  tok,
  output logic             out_valid,
  input  wire              out_ready,
  output tcpop_pkg::rec_t  out_rec
);

  tcpop_pkg::phase_t phase_r, phase_nxt;
  tcpop_pkg::rk_t    kind_r, kind_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [63:0]       shift_r, shift_nxt;
  logic [4:0]        num_r, num_nxt;
  logic [4:0]        total_r, total_nxt;
  logic              drop_r, drop_nxt;
  logic              out_valid_r;
  tcpop_pkg::rec_t   out_rec_r;

  logic              emit;
  tcpop_pkg::rec_t   rec;
  logic              pop;

  assign tok_ready = !out_valid_r || out_ready;
  assign pop       = tok_valid && tok_ready;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_comb begin
    logic           term;
    tcpop_pkg::rk_t term_kind;
    logic           go_data;
    logic [7:0]     left_dec;

    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    num_nxt   = num_r;
    total_nxt = total_r;
    drop_nxt  = drop_r;
    emit      = 1'b0;
    rec       = '0;
    term      = 1'b0;
    term_kind = tcpop_pkg::RK_TRUNC;
    go_data   = 1'b0;
    left_dec  = left_r - 8'd1;

    if (drop_r) begin
      // swallow the rest of a rejected list
      if (tok.last) begin
        drop_nxt  = 1'b0;
        phase_nxt = tcpop_pkg::PH_KIND;
      end
    end else begin
      case (phase_r)
        tcpop_pkg::PH_LEN: begin
          case (kind_r)
            tcpop_pkg::RK_MSS: begin
              left_nxt = tcpop_pkg::LEN_MSS;
              go_data  = 1'b1;
            end
            tcpop_pkg::RK_WSCALE: begin
              left_nxt = tcpop_pkg::LEN_WSCALE;
              go_data  = 1'b1;
            end
            tcpop_pkg::RK_TS: begin
              left_nxt = tcpop_pkg::LEN_TS;
              go_data  = 1'b1;
            end
            tcpop_pkg::RK_SACKOK: begin
              phase_nxt = tcpop_pkg::PH_KIND;
              emit      = 1'b1;
              rec.kind  = tcpop_pkg::RK_SACKOK;
              rec.done  = tok.last;
            end
            tcpop_pkg::RK_SACKBLK: begin
              if (tok.len_short) begin
                term      = 1'b1;
                term_kind = tcpop_pkg::RK_BADSACK;
              end else begin
                left_nxt = tok.len_left;
                go_data  = 1'b1;
                if (tok.len_mal) begin
                  kind_nxt = tcpop_pkg::RK_MALSACK;
                  if (tok.len_left == 8'd0) begin
                    go_data   = 1'b0;
                    phase_nxt = tcpop_pkg::PH_KIND;
                    emit      = 1'b1;
                    rec.kind  = tcpop_pkg::RK_MALSACK;
                    rec.done  = tok.last;
                  end
                end else begin
                  total_nxt = tok.len_left[7:3];
                  num_nxt   = '0;
                end
              end
            end
            default: phase_nxt = tcpop_pkg::PH_KIND;
          endcase
          if (go_data) begin
            phase_nxt = tcpop_pkg::PH_DATA;
            if (tok.last) begin
              term      = 1'b1;
              term_kind = tcpop_pkg::RK_TRUNC;
            end
          end
        end

        tcpop_pkg::PH_DATA: begin
          if (left_r == 8'd0) begin
            phase_nxt = tcpop_pkg::PH_KIND;
          end else begin
            shift_nxt = {shift_r[55:0], tok.data};
            left_nxt  = left_dec;
            if (tok.last && left_dec != 8'd0) begin
              term      = 1'b1;
              term_kind = tcpop_pkg::RK_TRUNC;
            end else begin
              case (kind_r)
                tcpop_pkg::RK_MSS: begin
                  if (left_dec == 8'd0) begin
                    phase_nxt = tcpop_pkg::PH_KIND;
                    emit      = 1'b1;
                    rec.kind  = tcpop_pkg::RK_MSS;
                    rec.first = {16'd0, shift_nxt[15:0]};
                    rec.done  = tok.last;
                  end
                end
                tcpop_pkg::RK_WSCALE: begin
                  phase_nxt = tcpop_pkg::PH_KIND;
                  emit      = 1'b1;
                  rec.kind  = tcpop_pkg::RK_WSCALE;
                  rec.first = {24'd0, tok.data};
                  rec.done  = tok.last;
                end
                tcpop_pkg::RK_TS: begin
                  if (left_dec == 8'd0) begin
                    phase_nxt  = tcpop_pkg::PH_KIND;
                    emit       = 1'b1;
                    rec.kind   = tcpop_pkg::RK_TS;
                    rec.first  = shift_nxt[63:32];
                    rec.second = shift_nxt[31:0];
                    rec.done   = tok.last;
                  end
                end
                tcpop_pkg::RK_MALSACK: begin
                  if (left_dec == 8'd0) begin
                    phase_nxt = tcpop_pkg::PH_KIND;
                    emit      = 1'b1;
                    rec.kind  = tcpop_pkg::RK_MALSACK;
                    rec.done  = tok.last;
                  end
                end
                tcpop_pkg::RK_SACKBLK: begin
                  // one record per completed eight-byte block
                  if (left_dec[2:0] == 3'd0) begin
                    num_nxt    = num_r + 5'd1;
                    emit       = 1'b1;
                    rec.kind   = tcpop_pkg::RK_SACKBLK;
                    rec.first  = shift_nxt[63:32];
                    rec.second = shift_nxt[31:0];
                    rec.idx    = num_r;
                    rec.cnt    = total_r;
                    rec.done   = (left_dec == 8'd0) && tok.last;
                    if (left_dec == 8'd0) begin
                      phase_nxt = tcpop_pkg::PH_KIND;
                    end
                  end
                end
                default: phase_nxt = tcpop_pkg::PH_KIND;
              endcase
            end
          end
        end

        default: begin
          phase_nxt = tcpop_pkg::PH_KIND;
          case (tok.kind)
            tcpop_pkg::RK_EOL, tcpop_pkg::RK_NOP: begin
              emit     = 1'b1;
              rec.kind = tok.kind;
              rec.done = tok.last;
            end
            tcpop_pkg::RK_MSS, tcpop_pkg::RK_WSCALE, tcpop_pkg::RK_SACKOK,
            tcpop_pkg::RK_SACKBLK, tcpop_pkg::RK_TS: begin
              kind_nxt = tok.kind;
              if (tok.last) begin
                term      = 1'b1;
                term_kind = tcpop_pkg::RK_TRUNC;
              end else begin
                phase_nxt = tcpop_pkg::PH_LEN;
              end
            end
            default: begin
              term      = 1'b1;
              term_kind = tcpop_pkg::RK_UNKNOWN;
            end
          endcase
        end
      endcase

      // error record overrides anything built above
      if (term) begin
        phase_nxt = tcpop_pkg::PH_KIND;
        left_nxt  = 8'd0;
        drop_nxt  = !tok.last;
        emit      = 1'b1;
        rec       = '0;
        rec.kind  = term_kind;
        rec.done  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tcpop_pkg::PH_KIND;
      kind_r      <= tcpop_pkg::RK_EOL;
      left_r      <= 8'd0;
      num_r       <= 5'd0;
      total_r     <= 5'd0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        left_r  <= left_nxt;
        num_r   <= num_nxt;
        total_r <= total_nxt;
        drop_r  <= drop_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shift_r <= shift_nxt;
    end
    if (pop && emit) begin
      out_rec_r <= rec;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcp_option_parser.sv @@
// Channel  Dir  Ports                              Contents
// in       in   in_tvalid/in_tready/in_tdata/      option byte, last-byte flag on tlast
//               in_tlast
// out      out  out_tvalid/out_tready/out_tdata/   decoded option record, kind on tuser,
//               out_tuser/out_tlast                end of list on tlast
//
// One byte is taken per cycle while the queue has room; the parser back end retires one queued
// byte per cycle while its record register is empty or being taken by the receiver.
// An input beat reaches the record through the classify stage, the queue and the record register.
// Reset is synchronous, active low, and empties the queue and the record register.
// Either side may stall independently; the queue of QUEUE_DEPTH bytes absorbs the slack.
`default_nettype none

module tcp_option_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] option_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [tcpop_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [31:0] value_first, [63:32] value_second, [68:64] block_index,
  // [73:69] block_count, [79:74] zero
  output logic [3:0]  out_tuser,  // [3:0] record_kind
  output logic        out_tlast   // list_done
);

  logic            f_valid, f_ready;
  tcpop_pkg::tok_t f_tok;
  logic            q_valid, q_ready;
  tcpop_pkg::tok_t q_tok;
  tcpop_pkg::rec_t rec;

  tcpop_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  tcpop_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_tok)
  );

  tcpop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (rec)
  );

  assign out_tdata = {6'd0, rec.cnt, rec.idx, rec.second, rec.first};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.done;

endmodule

`default_nettype wire

@@ rtl/tcpop_checker.sv @@
`default_nettype none
`include "tcp_option_parser_defines.svh"

module tcpop_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [tcpop_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire [3:0]  out_tuser,
  input wire        out_tlast
);

  logic is_err;
  logic two_vals;
  logic second_zero;

  assign is_err      = (out_tuser == tcpop_pkg::RK_UNKNOWN) ||
                       (out_tuser == tcpop_pkg::RK_TRUNC) ||
                       (out_tuser == tcpop_pkg::RK_BADSACK);
  assign two_vals    = (out_tuser == tcpop_pkg::RK_SACKBLK) || (out_tuser == tcpop_pkg::RK_TS);
  assign second_zero = (out_tdata[63:32] == 32'd0);

  `TCPOP_ASSERT(a_out_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped")
  `TCPOP_ASSERT_HOLD(a_out_hold_data, out_tdata, "out data changed under stall")
  `TCPOP_ASSERT(a_err_ends_list, out_tvalid && is_err |-> out_tlast, "error without list end")
  `TCPOP_ASSERT(a_second_zero, out_tvalid && !two_vals |-> second_zero, "stray value_second")

endmodule

bind tcp_option_parser tcpop_checker u_tcpop_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tcpop_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_BYTES = 1450;

  // Bit-true model of the option parser plus the queue of records it still owes.
  class option_checker;
    rec_t       records_due[$];
    int         errors;
    phase_t     phase;
    rk_t        cur_kind;
    logic [7:0] bytes_due;
    logic [63:0] acc;
    logic [4:0] blk_no;
    logic [4:0] blk_tot;
    bit         dropping;

    function new();
      errors    = 0;
      phase     = PH_KIND;
      cur_kind  = RK_EOL;
      bytes_due = '0;
      acc       = '0;
      blk_no    = '0;
      blk_tot   = '0;
      dropping  = 1'b0;
    endfunction

    function void push(rk_t k, logic [31:0] a, logic [31:0] c, logic [4:0] i,
                       logic [4:0] n, logic d);
      rec_t r;
      r.kind   = k;
      r.first  = a;
      r.second = c;
      r.idx    = i;
      r.cnt    = n;
      r.done   = d;
      records_due.push_back(r);
    endfunction

    function void abort(rk_t k, logic last);
      phase     = PH_KIND;
      bytes_due = '0;
      if (!last) dropping = 1'b1;
      push(k, '0, '0, '0, '0, 1'b1);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [4:0] idx;
      if (dropping) begin
        if (last) begin
          dropping = 1'b0;
          phase    = PH_KIND;
        end
        return;
      end
      case (phase)
        PH_LEN: begin
          case (cur_kind)
            RK_MSS:    bytes_due = LEN_MSS;
            RK_WSCALE: bytes_due = LEN_WSCALE;
            RK_TS:     bytes_due = LEN_TS;
            RK_SACKOK: begin
              phase = PH_KIND;
              push(RK_SACKOK, '0, '0, '0, '0, last);
              return;
            end
            RK_SACKBLK: begin
              if (b < SACK_HDR) begin
                abort(RK_BADSACK, last);
                return;
              end
              bytes_due = b - SACK_HDR;
              if (bytes_due == 0 || bytes_due[2:0] != 0) begin
                cur_kind = RK_MALSACK;
                if (bytes_due == 0) begin
                  phase = PH_KIND;
                  push(RK_MALSACK, '0, '0, '0, '0, last);
                  return;
                end
              end else begin
                blk_tot = bytes_due[7:3];
                blk_no  = '0;
              end
            end
            default: begin
              phase = PH_KIND;
              return;
            end
          endcase
          phase = PH_DATA;
          acc   = '0;
          if (last) abort(RK_TRUNC, last);
        end
        PH_DATA: begin
          if (bytes_due == 0) begin
            phase = PH_KIND;
            return;
          end
          acc       = {acc[55:0], b};
          bytes_due = bytes_due - 8'd1;
          if (last && bytes_due != 0) begin
            abort(RK_TRUNC, last);
            return;
          end
          case (cur_kind)
            RK_MSS: if (bytes_due == 0) begin
              phase = PH_KIND;
              push(RK_MSS, {16'h0, acc[15:0]}, '0, '0, '0, last);
            end
            RK_WSCALE: begin
              phase = PH_KIND;
              push(RK_WSCALE, {24'h0, acc[7:0]}, '0, '0, '0, last);
            end
            RK_TS: if (bytes_due == 0) begin
              phase = PH_KIND;
              push(RK_TS, acc[63:32], acc[31:0], '0, '0, last);
            end
            RK_MALSACK: if (bytes_due == 0) begin
              phase = PH_KIND;
              push(RK_MALSACK, '0, '0, '0, '0, last);
            end
            RK_SACKBLK: if (bytes_due[2:0] == 0) begin
              idx    = blk_no;
              blk_no = blk_no + 5'd1;
              if (bytes_due == 0) phase = PH_KIND;
              push(RK_SACKBLK, acc[63:32], acc[31:0], idx, blk_tot,
                   (bytes_due == 0) ? last : 1'b0);
            end
            default: phase = PH_KIND;
          endcase
        end
        default: begin
          phase = PH_KIND;
          case (b)
            OPT_EOL: begin
              push(RK_EOL, '0, '0, '0, '0, last);
              return;
            end
            OPT_NOP: begin
              push(RK_NOP, '0, '0, '0, '0, last);
              return;
            end
            OPT_MSS:    cur_kind = RK_MSS;
            OPT_WSCALE: cur_kind = RK_WSCALE;
            OPT_SACKOK: cur_kind = RK_SACKOK;
            OPT_SACK:   cur_kind = RK_SACKBLK;
            OPT_TS:     cur_kind = RK_TS;
            default: begin
              abort(RK_UNKNOWN, last);
              return;
            end
          endcase
          if (last) begin
            abort(RK_TRUNC, last);
            return;
          end
          phase = PH_LEN;
        end
      endcase
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected record: kind=%0d first=%h second=%h idx=%0d cnt=%0d done=%b",
                   got.kind, got.first, got.second, got.idx, got.cnt, got.done);
        return;
      end
      want = records_due.pop_front();
      if (got.kind !== want.kind || got.first !== want.first || got.second !== want.second ||
          got.idx !== want.idx || got.cnt !== want.cnt || got.done !== want.done) begin
        errors++;
        if (errors <= 10) begin
          $display("record mismatch at %0t", $time);
          $display("  exp kind=%0d first=%h second=%h idx=%0d cnt=%0d done=%b",
                   want.kind, want.first, want.second, want.idx, want.cnt, want.done);
          $display("  got kind=%0d first=%h second=%h idx=%0d cnt=%0d done=%b",
                   got.kind, got.first, got.second, got.idx, got.cnt, got.done);
        end
      end
    endfunction

    function int pending();
      return records_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  option_checker chk;
  logic [7:0]    list_q[$];
  int            bytes_sent;
  int            records_seen;
  int            idle_cycles;
  bit            sender_quiet;
  bit            hold_done;

  tcp_option_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // input beats feed the model, output beats are checked against it
  always @(posedge clk) begin
    rec_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) chk.take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind   = rk_t'(out_tuser);
        got.first  = out_tdata[31:0];
        got.second = out_tdata[63:32];
        got.idx    = out_tdata[68:64];
        got.cnt    = out_tdata[73:69];
        got.done   = out_tlast;
        chk.check_record(got);
        records_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    int stall;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!hold_done && records_seen >= 150) begin
        out_tready <= 1'b0;
        repeat (120) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:54]:  stall = 0;
          [55:89]: stall = $urandom_range(1, 3);
          default: stall = $urandom_range(8, 25);
        endcase
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!sender_quiet)
      case ($urandom_range(0, 99)) inside
        [0:59]:  gap = 0;
        [60:91]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(10, 30);
      endcase
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_list();
    foreach (list_q[i]) send_byte(list_q[i], i == list_q.size() - 1);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) list_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_option();
    int sel;
    int n;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 6) list_q.push_back(OPT_EOL);
    else if (sel < 14) list_q.push_back(OPT_NOP);
    else if (sel < 26) begin
      list_q.push_back(OPT_MSS);
      list_q.push_back($urandom_range(0, 1) ? 8'd4 : 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        0: begin
          list_q.push_back(8'h00);
          list_q.push_back(8'h00);
        end
        1: begin
          list_q.push_back(8'hFF);
          list_q.push_back(8'hFF);
        end
        default: add_bytes(2);
      endcase
    end else if (sel < 36) begin
      list_q.push_back(OPT_WSCALE);
      list_q.push_back($urandom_range(0, 1) ? 8'd3 : 8'($urandom_range(0, 255)));
      add_bytes(1);
    end else if (sel < 44) begin
      list_q.push_back(OPT_SACKOK);
      list_q.push_back($urandom_range(0, 1) ? 8'd2 : 8'($urandom_range(0, 255)));
    end else if (sel < 58) begin
      list_q.push_back(OPT_TS);
      list_q.push_back($urandom_range(0, 1) ? 8'd10 : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) repeat (8) list_q.push_back(8'hFF);
      else add_bytes(8);
    end else if (sel < 76) begin
      if ($urandom_range(0, 49) == 0) n = $urandom_range(0, 1) ? 31 : $urandom_range(5, 30);
      else n = $urandom_range(1, 4);
      list_q.push_back(OPT_SACK);
      list_q.push_back(8'(2 + 8 * n));
      add_bytes(8 * n);
    end else if (sel < 84) begin
      // payload zero or not a multiple of eight
      if ($urandom_range(0, 3) == 0) n = 2;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(3, 255);
      else n = $urandom_range(3, 20);
      if (n > 2 && (n - 2) % 8 == 0) n++;
      list_q.push_back(OPT_SACK);
      list_q.push_back(8'(n));
      add_bytes(n - 2);
    end else if (sel < 88) begin
      list_q.push_back(OPT_SACK);
      list_q.push_back(8'($urandom_range(0, 1)));
    end else if (sel < 92) begin
      b = 8'($urandom_range(6, 255));
      if (b == OPT_TS) b = 8'd7;
      list_q.push_back(b);
    end else add_bytes($urandom_range(1, 6));
  endtask

  initial begin
    int k;
    bit drained;
    chk          = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    bytes_sent   = 0;
    records_seen = 0;
    idle_cycles  = 0;
    sender_quiet = 1'b0;
    drained      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short options, then bad sack length with dropped tail
    list_q = {OPT_NOP, OPT_WSCALE, 8'd3, 8'hFF, OPT_SACKOK, 8'd2, OPT_EOL};
    send_list();
    list_q = {OPT_SACK, 8'd1, 8'hAA, 8'h00};
    send_list();
    // sack with empty payload, mss cut short, unknown kind, truncation at kind byte
    list_q = {OPT_SACK, 8'd2};
    send_list();
    list_q = {OPT_MSS, 8'd4, 8'h00};
    send_list();
    list_q = {8'hFF};
    send_list();
    list_q = {OPT_TS};
    send_list();
    // sack payload of three bytes is skipped
    list_q = {OPT_SACK, 8'd5, 8'h01, 8'h02, 8'h03};
    send_list();

    while (bytes_sent < TARGET_BYTES) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      list_q.delete();
      repeat ($urandom_range(1, 6)) add_option();
      if ($urandom_range(0, 9) == 0 && list_q.size() > 1) begin
        k = $urandom_range(1, list_q.size() - 1);
        while (list_q.size() > k) void'(list_q.pop_back());
      end
      send_list();
      // hold the sender until every record owed so far has come out
      if (!drained && bytes_sent >= 700) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (chk.pending() != 0) @(negedge clk);
        drained = 1'b1;
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (chk.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    chk.errors += chk.pending();
    if (chk.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tcpop_pkg.sv
rtl/tcpop_front.sv
rtl/tcpop_fifo.sv
rtl/tcpop_back.sv
rtl/tcp_option_parser.sv
rtl/tcpop_checker.sv
tb/sv/tb.sv
